// ----- rtl/delta_patch_decoder_defines.svh -----
// Assertion macros for the delta patch decoder checker
`ifndef DELTA_PATCH_DECODER_DEFINES_SVH
`define DELTA_PATCH_DECODER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define DPD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is low
`define DPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ----- rtl/dpd_pkg.sv -----
// Types, constants and helpers for the delta patch decoder
package dpd_pkg;

    localparam int INDEX_BITS = 21;
    localparam int WORD_W     = 16;
    localparam int CFG_W      = 21;
    localparam int SKIP_W     = 2 * WORD_W;
    localparam int SUM_W      = ((INDEX_BITS > SKIP_W) ? INDEX_BITS : SKIP_W) + 1;
    localparam int CMP_W      = (INDEX_BITS > CFG_W) ? INDEX_BITS : CFG_W;

    localparam logic [INDEX_BITS-1:0] POS_MAX = {INDEX_BITS{1'b1}};
    localparam logic [CFG_W-1:0] STATE_WORDS_RESET = CFG_W'(1048576);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_SKIP    = 3'd1,
        PH_DATA    = 3'd2,
        PH_LONG_LO = 3'd3,
        PH_LONG_HI = 3'd4
    } t_phase;

    typedef struct packed {
        logic [INDEX_BITS-1:0] word_index;
        logic [WORD_W-1:0]     value;
        logic                  done_res;
        logic                  out_of_range;
    } t_result;

    // position + amount, clamped at the top of the index range
    function automatic logic [INDEX_BITS-1:0] sat_add(
        input logic [INDEX_BITS-1:0] pos,
        input logic [SKIP_W-1:0]     amt
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(pos) + SUM_W'(amt);
        if (sum > SUM_W'(POS_MAX)) begin
            return POS_MAX;
        end
        return sum[INDEX_BITS-1:0];
    endfunction

endpackage

// ----- rtl/dpd_in_reg.sv -----
// Input register: holds one patch word until the parser takes it
module dpd_in_reg
    import dpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [WORD_W-1:0] i_patch_word,
    input  logic              i_take,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_word,
    output logic              o_in_stall
);

    logic              r_valid;
    logic [WORD_W-1:0] r_word;

    assign o_in_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_word <= i_patch_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ----- rtl/dpd_parser.sv -----
// Patch parser: phase, run count, position and pending long skip
module dpd_parser
    import dpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [WORD_W-1:0] i_word,
    input  logic [CFG_W-1:0]  i_state_words,
    output logic              o_has_result,
    output t_result           o_result
);

    t_phase                r_phase, n_phase;
    logic [WORD_W-1:0]     r_run_left, n_run_left;
    logic [INDEX_BITS-1:0] r_pos, n_pos;
    logic [WORD_W-1:0]     r_long_low, n_long_low;

    logic                  adv;
    logic [SKIP_W-1:0]     addend;
    logic [SKIP_W-1:0]     long_skip;

    assign long_skip = {i_word, r_long_low};

    always_comb begin
        n_phase      = r_phase;
        n_run_left   = r_run_left;
        n_long_low   = r_long_low;
        adv          = 1'b0;
        addend       = '0;
        o_has_result = 1'b0;
        o_result     = '0;
        case (r_phase)
            PH_SKIP: begin
                adv     = 1'b1;
                addend  = SKIP_W'(i_word);
                n_phase = PH_DATA;
            end
            PH_DATA: begin
                if (r_run_left == '0) begin
                    // stray data phase: treat the word as a header
                    if (i_word != '0) begin
                        n_run_left = i_word;
                        n_phase    = PH_SKIP;
                    end else begin
                        n_phase    = PH_LONG_LO;
                    end
                end else begin
                    o_has_result          = 1'b1;
                    o_result.word_index   = r_pos;
                    o_result.value        = i_word;
                    o_result.out_of_range = CMP_W'(r_pos) >= CMP_W'(i_state_words);
                    adv        = 1'b1;
                    addend     = SKIP_W'(1);
                    n_run_left = r_run_left - WORD_W'(1);
                    if (r_run_left == WORD_W'(1)) begin
                        n_phase = PH_HEADER;
                    end
                end
            end
            PH_LONG_LO: begin
                n_long_low = i_word;
                n_phase    = PH_LONG_HI;
            end
            PH_LONG_HI: begin
                n_phase = PH_HEADER;
                if (long_skip == '0) begin
                    o_has_result      = 1'b1;
                    o_result.done_res = 1'b1;
                end else begin
                    adv    = 1'b1;
                    addend = long_skip;
                end
            end
            default: begin
                if (i_word != '0) begin
                    n_run_left = i_word;
                    n_phase    = PH_SKIP;
                end else begin
                    n_phase    = PH_LONG_LO;
                end
            end
        endcase
    end

    always_comb begin
        n_pos = r_pos;
        if (adv) begin
            n_pos = sat_add(r_pos, addend);
        end else if (r_phase == PH_LONG_HI) begin
            // end marker returns the position to zero
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_run_left <= '0;
            r_pos      <= '0;
            r_long_low <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_run_left <= n_run_left;
            r_pos      <= n_pos;
            r_long_low <= n_long_low;
        end
    end

endmodule

// ----- rtl/dpd_out_reg.sv -----
// Result register toward the downstream side
module dpd_out_reg
    import dpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_out_stall,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- rtl/delta_patch_decoder.sv -----
// Delta patch decoder top level: turns patch words into state word writes
//
//   channel   direction  handshake                  payload
//   patch in  input      i_in_valid / o_in_stall    i_patch_word
//   writes    output     o_out_valid / i_out_stall  o_word_index, o_value,
//                                                   o_done_res, o_out_of_range
//   config    input      i_cfg_valid / o_cfg_ready  i_cfg_state_words
//
// One patch word per cycle while the write side does not stall; a taken word's result
// goes through the input register, then the parse step into the result register.
// Synchronous active-low reset returns the parser to expecting a header, the
// position to zero and state_words to 1048576.
// A stall on the write side holds the result register and, once the input
// register is full, stalls the patch input in the same cycle.
module delta_patch_decoder
    import dpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [WORD_W-1:0]     i_patch_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [INDEX_BITS-1:0] o_word_index,
    output logic [WORD_W-1:0]     o_value,
    output logic                  o_done_res,
    output logic                  o_out_of_range,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_state_words
);

    logic [CFG_W-1:0]  r_state_words_q;
    logic              in_valid;
    logic [WORD_W-1:0] in_word;
    logic              out_ready;
    logic              step;
    logic              has_result;
    t_result           result;
    t_result           out_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_words_q <= STATE_WORDS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_state_words_q <= i_cfg_state_words;
        end
    end

    assign step = in_valid && out_ready;

    dpd_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_patch_word (i_patch_word),
        .i_take       (step),
        .o_valid      (in_valid),
        .o_word       (in_word),
        .o_in_stall   (o_in_stall)
    );

    dpd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_word        (in_word),
        .i_state_words (r_state_words_q),
        .o_has_result  (has_result),
        .o_result      (result)
    );

    dpd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step && has_result),
        .i_result    (result),
        .i_out_stall (i_out_stall),
        .o_ready     (out_ready),
        .o_valid     (o_out_valid),
        .o_result    (out_result)
    );

    assign o_word_index   = out_result.word_index;
    assign o_value        = out_result.value;
    assign o_done_res     = out_result.done_res;
    assign o_out_of_range = out_result.out_of_range;

endmodule

// ----- rtl/dpd_checker.sv -----
// Port-level checker for the delta patch decoder, bound to the top level
`include "delta_patch_decoder_defines.svh"

module dpd_checker
    import dpd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [INDEX_BITS-1:0] o_word_index,
    input logic [WORD_W-1:0]     o_value,
    input logic                  o_done_res,
    input logic                  o_out_of_range
);

    // a stalled write request keeps its payload
    `DPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_word_index) && $stable(o_value) && $stable(o_done_res) && $stable(o_out_of_range))

    // the end marker carries no write
    `DPD_ASSERT_IMPLY(a_done_clean, i_clk, i_rst_n, o_out_valid && o_done_res, o_word_index == '0 && o_value == '0 && !o_out_of_range)

    // input backpressure only comes from a blocked result register
    `DPD_ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

endmodule

bind delta_patch_decoder dpd_checker u_dpd_checker (.*);
